[rtl/sst_pkg.sv]
// Shared types and codes for the sorted set table.
// Holds the request and result payloads and the bundles between controller and datapath.
// Used by sst_ctrl, sst_datapath and sorted_set_table.
package sst_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic       done_res;
    logic       full_res;
    logic [8:0] count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic probe_rd;
    logic probe_upd;
    logic check_rd;
    logic ins_init;
    logic del_init;
    logic rd_below;
    logic rd_above;
    logic wr_down;
    logic wr_up;
    logic place;
    logic remove;
    logic respond;
    logic res_done;
    logic res_full;
  } ctl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       in_range;
    logic       hit;
    logic       room;
    logic       ins_more;
    logic       del_more;
  } sts_t;

endpackage

[rtl/sst_ctrl.sv]
// Controller state machine for the sorted set table.
// Sequences the binary search, membership check and entry shifts.
// Depends on sst_pkg for the command and status bundles.
module sst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sst_pkg::sts_t sts,
  output sst_pkg::ctl_t ctl,
  output logic          busy
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SEARCH   = 8'b0000_0010,
    S_PROBE    = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_INS_TEST = 8'b0001_0000,
    S_INS_WR   = 8'b0010_0000,
    S_DEL_TEST = 8'b0100_0000,
    S_DEL_WR   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.in_range) begin
          ctl.probe_rd = 1'b1;
          state_next = S_PROBE;
        end else begin
          ctl.check_rd = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_PROBE: begin
        ctl.probe_upd = 1'b1;
        state_next = S_SEARCH;
      end
      S_CHECK: begin
        state_next = S_IDLE;
        if (sts.command == sst_pkg::CMD_INSERT) begin
          if (sts.hit) begin
            ctl.respond = 1'b1;
          end else if (!sts.room) begin
            ctl.respond = 1'b1;
            ctl.res_full = 1'b1;
          end else begin
            ctl.ins_init = 1'b1;
            state_next = S_INS_TEST;
          end
        end else if (sts.command == sst_pkg::CMD_DELETE) begin
          if (sts.hit) begin
            ctl.del_init = 1'b1;
            state_next = S_DEL_TEST;
          end else begin
            ctl.respond = 1'b1;
          end
        end else if (sts.command == sst_pkg::CMD_SEARCH) begin
          ctl.respond = 1'b1;
          ctl.res_done = sts.hit;
        end else begin
          ctl.respond = 1'b1;
        end
      end
      S_INS_TEST: begin
        if (sts.ins_more) begin
          ctl.rd_below = 1'b1;
          state_next = S_INS_WR;
        end else begin
          ctl.place = 1'b1;
          ctl.respond = 1'b1;
          ctl.res_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_INS_WR: begin
        ctl.wr_down = 1'b1;
        state_next = S_INS_TEST;
      end
      S_DEL_TEST: begin
        if (sts.del_more) begin
          ctl.rd_above = 1'b1;
          state_next = S_DEL_WR;
        end else begin
          ctl.remove = 1'b1;
          ctl.respond = 1'b1;
          ctl.res_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DEL_WR: begin
        ctl.wr_up = 1'b1;
        state_next = S_DEL_TEST;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/sst_datapath.sv]
// Datapath for the sorted set table: entry memory, search bounds, shift cursor and count.
// Acts on commands from sst_ctrl and returns status to it.
// Depends on sst_pkg for payload and bundle types.
module sst_datapath #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  sst_pkg::req_t req,
  input  sst_pkg::ctl_t ctl,
  output sst_pkg::sts_t sts,
  output logic          strobe,
  output sst_pkg::rsp_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               wr_en;

  logic [1:0]         cmd;
  logic signed [31:0] val;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW:0]        mid_sum;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      idx_dec;
  logic [CW-1:0]      idx_inc;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign idx_dec = idx - CW'(1);
  assign idx_inc = idx + CW'(1);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = lo[AW-1:0];
    if (ctl.probe_rd) begin
      rd_addr = mid[AW-1:0];
    end else if (ctl.rd_below) begin
      rd_addr = idx_dec[AW-1:0];
    end else if (ctl.rd_above) begin
      rd_addr = idx_inc[AW-1:0];
    end else if (!ctl.check_rd) begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = ctl.wr_down | ctl.wr_up | ctl.place;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    if (ctl.place) begin
      wr_addr = lo[AW-1:0];
      wr_data = val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.place) begin
      count_next = count + CW'(1);
    end else if (ctl.remove) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= ctl.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= req.command;
      val <= req.value;
      lo  <= '0;
      hi  <= count;
    end else if (ctl.probe_upd) begin
      if ($signed(rd_data) < val) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (ctl.ins_init) begin
      idx <= count;
    end else if (ctl.del_init) begin
      idx <= lo;
    end else if (ctl.wr_down) begin
      idx <= idx_dec;
    end else if (ctl.wr_up) begin
      idx <= idx_inc;
    end
    if (ctl.respond) begin
      result.done_res <= ctl.res_done;
      result.full_res <= ctl.res_full;
      result.count    <= 9'(count_next);
    end
  end

  assign sts.command  = cmd;
  assign sts.in_range = (lo < hi);
  assign sts.hit      = (lo < count) && (rd_data == val);
  assign sts.room     = (count < DEPTH_C);
  assign sts.ins_more = (idx > lo);
  assign sts.del_more = (idx_inc < count);

endmodule

[rtl/sorted_set_table.sv]
// Top level of the sorted set table: ascending set of distinct signed 32-bit keys.
// Joins the controller sst_ctrl and the datapath sst_datapath.
// Depends on sst_pkg for the request and result types.
//
//   Channel   Handshake        Payload          Transfer when
//   request   start / busy     req (req_t)      start high and busy low at a clock edge
//   result    strobe           result (rsp_t)   every cycle strobe is high
//
// The binary search and the membership check come first. An insert or a delete that changes
// the set then moves the entries one at a time, each with a read and then a write, since
// the entry memory has a single read port.
// Reset clears the count and the control state; the entry memory is not cleared.
// The result shows in the cycle after the request finishes, and a new request may be
// accepted in that same cycle. The receiver cannot stall the result.
module sorted_set_table #(
  parameter int DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sst_pkg::req_t req,
  output logic          strobe,
  output sst_pkg::rsp_t result
);

  sst_pkg::ctl_t ctl;
  sst_pkg::sts_t sts;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  sst_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .ctl    (ctl),
    .sts    (sts),
    .strobe (strobe),
    .result (result)
  );

endmodule
